FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the LFU cache table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/lfu_pkg.sv
// Types and constants shared by the LFU cache table.
package lfu_pkg;

    // Operation codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [4:0]  CAP_RESET  = 5'd16;
    localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic [31:0] COUNT_ONE  = 32'd1;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

    // One stored table entry
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] count;
        logic [31:0] stamp;
    } t_entry;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_RESP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
        logic out_load;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic issue_last;
        logic pipe_empty;
    } t_dp_sts;

endpackage

FILE: rtl/lfu_cfg_if.sv
// Configuration write channel carrying the capacity register.
interface lfu_cfg_if import lfu_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [4:0] capacity_in_use;

    modport source (output valid, output capacity_in_use, input ready);
    modport sink   (input valid, input capacity_in_use, output ready);
endinterface

FILE: rtl/lfu_in_if.sv
// Request channel: one get or put item.
interface lfu_in_if import lfu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [31:0]        lookup_key;
    logic signed [31:0] write_value;

    modport source (output valid, output cmd, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input cmd, input lookup_key, input write_value,
                    output ready);
endinterface

FILE: rtl/lfu_out_if.sv
// Result channel: hit flag and read value of one item.
interface lfu_out_if import lfu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

FILE: rtl/lfu_ctrl.sv
// Controller state machine sequencing scan, drain, update and result hand-off.
`include "assert_macros.svh"
module lfu_ctrl import lfu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_RESP;
            end
            ST_RESP: begin
                // hand the result over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_resp_delivers, i_clk, i_rst_n, (r_state == ST_RESP) && !r_out_valid |=> r_out_valid && (r_state == ST_IDLE), "result not loaded from a free output register")

endmodule

FILE: rtl/lfu_dpath.sv
// Datapath: entry memory, scan pipeline, hit/free/victim search and update.
`include "assert_macros.svh"
module lfu_dpath import lfu_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_cap,
    input  logic               i_cmd_in,
    input  logic [31:0]        i_key,
    input  logic signed [31:0] i_wval,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic               o_hit,
    output logic signed [31:0] o_rval
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OW = $clog2(MAX_ENTRIES + 1);

    // Entry memory and per-entry valid bits
    t_entry                 r_mem [MAX_ENTRIES];
    t_entry                 r_rd;
    logic [MAX_ENTRIES-1:0] r_valid;

    logic [4:0]    r_cap;
    logic [OW-1:0] r_occ;
    logic [31:0]   r_tick;

    // Captured item
    logic        r_cmd_q;
    logic [31:0] r_key_q;
    logic [31:0] r_wval_q;

    // Scan pipeline
    logic [IW-1:0] r_addr;
    logic          r_s1_v;
    logic [IW-1:0] r_s1_idx;
    logic          r_s2_v;
    logic [IW-1:0] r_s2_idx;
    logic          r_s2_ev;
    logic          r_s2_match;
    logic [31:0]   r_s2_age;
    logic [31:0]   r_s2_cnt;
    logic [31:0]   r_s2_val;

    // Search results
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [31:0]   r_hit_val;
    logic [31:0]   r_hit_cnt;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic          r_vic_found;
    logic [IW-1:0] r_vic_idx;
    logic [31:0]   r_vic_cnt;
    logic [31:0]   r_vic_age;

    // Result registers
    logic        r_pend_hit;
    logic [31:0] r_pend_val;
    logic        r_out_hit;
    logic [31:0] r_out_val;

    // Update decisions
    logic          cap_zero;
    logic [OW-1:0] cap_clamp;
    logic [31:0]   cnt_sat;
    logic          n_wr_en;
    logic [IW-1:0] n_wr_idx;
    t_entry        n_wr_entry;
    logic          n_set_valid;
    logic          n_occ_inc;
    logic [31:0]   n_res_val;

    assign o_sts.issue_last = (r_addr == IW'(MAX_ENTRIES - 1));
    assign o_sts.pipe_empty = !r_s1_v && !r_s2_v;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_cap;
        end
    end

    // Memory read and write ports
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr];
        if (n_wr_en) begin
            r_mem[n_wr_idx] <= n_wr_entry;
        end
    end

    // Capture item and advance scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_q  <= i_cmd_in;
            r_key_q  <= i_key;
            r_wval_q <= i_wval;
        end
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.load) begin
            r_addr <= '0;
        end else if (i_cmd.issue && !o_sts.issue_last) begin
            r_addr <= IW'(r_addr + 1'b1);
        end
    end

    // Pipeline stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.issue;
            r_s2_v <= r_s1_v;
        end
    end

    // Compare stage: key match and age of each read entry
    always_ff @(posedge i_clk) begin
        r_s1_idx   <= r_addr;
        r_s2_idx   <= r_s1_idx;
        r_s2_ev    <= r_valid[r_s1_idx];
        r_s2_match <= r_valid[r_s1_idx] && (r_rd.key == r_key_q);
        r_s2_age   <= r_tick - r_rd.stamp;
        r_s2_cnt   <= r_rd.count;
        r_s2_val   <= r_rd.value;
    end

    // Accumulate first hit, first free slot and eviction victim
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end else if (r_s2_v) begin
            if (r_s2_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_s2_idx;
                r_hit_val <= r_s2_val;
                r_hit_cnt <= r_s2_cnt;
            end
            if (!r_s2_ev && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_s2_idx;
            end
            if (r_s2_ev && (!r_vic_found || (r_s2_cnt < r_vic_cnt) ||
                            ((r_s2_cnt == r_vic_cnt) && (r_s2_age > r_vic_age)))) begin
                r_vic_found <= 1'b1;
                r_vic_idx   <= r_s2_idx;
                r_vic_cnt   <= r_s2_cnt;
                r_vic_age   <= r_s2_age;
            end
        end
    end

    // Clamp capacity to the table size
    always_comb begin
        cap_zero = (r_cap == 5'd0);
        if (32'(r_cap) > 32'(MAX_ENTRIES)) begin
            cap_clamp = OW'(MAX_ENTRIES);
        end else begin
            cap_clamp = OW'(r_cap);
        end
    end

    assign cnt_sat = (r_hit_cnt == COUNT_MAX) ? r_hit_cnt : r_hit_cnt + COUNT_ONE;

    // Decide the write-back and result of the item
    always_comb begin
        n_wr_en          = 1'b0;
        n_wr_idx         = r_hit_idx;
        n_wr_entry.key   = r_key_q;
        n_wr_entry.value = r_hit_val;
        n_wr_entry.count = cnt_sat;
        n_wr_entry.stamp = r_tick;
        n_set_valid      = 1'b0;
        n_occ_inc        = 1'b0;
        n_res_val        = 32'd0;
        if (r_cmd_q == CMD_GET) begin
            if (r_hit) begin
                n_wr_en   = i_cmd.commit;
                n_res_val = r_hit_val;
            end else begin
                n_res_val = MISS_VALUE;
            end
        end else if (!cap_zero) begin
            n_wr_en          = i_cmd.commit;
            n_wr_entry.value = r_wval_q;
            if (!r_hit) begin
                n_wr_entry.count = COUNT_ONE;
                n_set_valid      = i_cmd.commit;
                if (r_occ < cap_clamp) begin
                    n_wr_idx  = r_free_idx;
                    n_occ_inc = i_cmd.commit;
                end else begin
                    // full: replace the victim in place
                    n_wr_idx = r_vic_idx;
                end
            end
        end
    end

    // Commit valid bits, occupancy and tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_tick  <= '0;
        end else if (i_cmd.commit) begin
            r_tick <= r_tick + 32'd1;
            if (n_set_valid) begin
                r_valid[n_wr_idx] <= 1'b1;
            end
            if (n_occ_inc) begin
                r_occ <= OW'(r_occ + 1'b1);
            end
        end
    end

    // Hold the pending result and move it to the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_pend_hit <= r_hit;
            r_pend_val <= n_res_val;
        end
        if (i_cmd.out_load) begin
            r_out_hit <= r_pend_hit;
            r_out_val <= r_pend_val;
        end
    end

    assign o_hit  = r_out_hit;
    assign o_rval = r_out_val;

    `ASSERT_CLK(a_occ_matches_valid, i_clk, i_rst_n, $countones(r_valid) == r_occ, "occupancy differs from number of valid entries")
    `ASSERT_CLK(a_tick_per_item, i_clk, i_rst_n, i_cmd.commit |=> r_tick == $past(r_tick) + 32'd1, "tick did not advance on commit")
    `ASSERT_NEVER(a_put_full_no_victim, i_clk, i_rst_n, i_cmd.commit && (r_cmd_q == CMD_PUT) && !cap_zero && !r_hit && (r_occ >= cap_clamp) && !r_vic_found, "put miss in a full table without a victim")

endmodule

FILE: rtl/lfu_cache_table_core.sv
// LFU cache table: get/put key-value cache with least-frequently-used eviction.
//
// Channels: i_in takes one item (cmd 0 get, 1 put, lookup_key, write_value);
// o_out returns one result per item (hit, read_value: stored value on a get
// hit, -1 on a get miss, 0 on every put). i_cfg writes capacity_in_use and is
// always ready; write it only while no item is in flight.
// Each item is finished before the block is ready again: the entry memory
// has one read port, so the search for the key, the first free slot and the
// eviction victim reads one entry per cycle, followed by a pipeline drain,
// a write-back and the hand-over of the result.
// The result is held in an output register; the next item is accepted while
// it waits. If the receiver stalls, the block finishes the next item and then
// holds it until the output register is free.
// Reset (synchronous, active low) clears all valid bits, the occupancy count
// and the tick, and sets the capacity to 16; it needs no clearing pass.
module lfu_cache_table_core import lfu_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lfu_cfg_if.sink  i_cfg,
    lfu_in_if.sink   i_in,
    lfu_out_if.source o_out
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;
    logic    out_valid;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    lfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    lfu_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg.valid),
        .i_cfg_cap (i_cfg.capacity_in_use),
        .i_cmd_in  (i_in.cmd),
        .i_key     (i_in.lookup_key),
        .i_wval    (i_in.write_value),
        .i_cmd     (dp_cmd),
        .o_sts     (dp_sts),
        .o_hit     (o_out.hit),
        .o_rval    (o_out.read_value)
    );

endmodule

FILE: test/tb_lfu_cache_table_core.sv
// Self-checking testbench for the LFU cache table core.
module tb_lfu_cache_table_core import lfu_pkg::*; ();

    localparam int TABLE_SIZE    = 16;
    localparam int SETTLE_CYCLES = 2 * TABLE_SIZE + 12;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
    } t_lookup_result;

    logic i_clk;
    logic i_rst_n;

    lfu_cfg_if cfg_bus ();
    lfu_in_if  req_bus ();
    lfu_out_if rsp_bus ();

    lfu_cache_table_core #(
        .MAX_ENTRIES(TABLE_SIZE)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_in   (req_bus),
        .o_out  (rsp_bus)
    );

    // Shadow copy of the cache contents
    bit          shadow_valid [TABLE_SIZE];
    logic [31:0] shadow_key   [TABLE_SIZE];
    logic [31:0] shadow_value [TABLE_SIZE];
    logic [31:0] shadow_count [TABLE_SIZE];
    logic [31:0] shadow_stamp [TABLE_SIZE];
    logic [31:0] shadow_tick;
    int unsigned shadow_fill;
    logic [4:0]  shadow_capacity;

    t_lookup_result expected_lookups[$];
    logic [31:0]    key_pool[$];
    int             error_count;
    bit             sender_bursty;
    bit             receiver_stalls;
    int             burst_left;
    int             stall_left;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Bump the use count (saturating) and stamp the entry with the current tick
    function automatic void touch_entry(input int slot);
        if (shadow_count[slot] != COUNT_MAX) begin
            shadow_count[slot] = shadow_count[slot] + 1;
        end
        shadow_stamp[slot] = shadow_tick;
    endfunction

    // Apply one get or put to the shadow table and return the result it gives
    function automatic t_lookup_result predict_lookup(input logic cmd, input logic [31:0] key,
                                                      input logic [31:0] wdata);
        t_lookup_result res;
        int             slot;
        int             i;
        int unsigned    limit;
        bit             present;
        bit             have_victim;
        logic [31:0]    best_count;
        logic [31:0]    best_age;
        logic [31:0]    age;

        slot        = 0;
        present     = 1'b0;
        have_victim = 1'b0;
        best_count  = '0;
        best_age    = '0;
        limit       = (shadow_capacity > TABLE_SIZE) ? TABLE_SIZE : shadow_capacity;
        res.read_value = (cmd == CMD_GET) ? MISS_VALUE : '0;

        for (i = 0; i < TABLE_SIZE; i++) begin
            if (!present && shadow_valid[i] && shadow_key[i] == key) begin
                present = 1'b1;
                slot    = i;
            end
        end

        if (cmd == CMD_GET) begin
            if (present) begin
                touch_entry(slot);
                res.read_value = shadow_value[slot];
            end
        end else if (limit != 0) begin
            if (present) begin
                shadow_value[slot] = wdata;
                touch_entry(slot);
            end else begin
                // Take the lowest free slot while below capacity, else evict
                slot = -1;
                if (shadow_fill < limit) begin
                    for (i = TABLE_SIZE - 1; i >= 0; i--) begin
                        if (!shadow_valid[i]) slot = i;
                    end
                end
                if (slot < 0) begin
                    for (i = 0; i < TABLE_SIZE; i++) begin
                        age = shadow_tick - shadow_stamp[i];
                        if (shadow_valid[i] && (!have_victim || shadow_count[i] < best_count ||
                            (shadow_count[i] == best_count && age > best_age))) begin
                            have_victim = 1'b1;
                            slot        = i;
                            best_count  = shadow_count[i];
                            best_age    = age;
                        end
                    end
                    shadow_valid[slot] = 1'b0;
                    shadow_fill        = shadow_fill - 1;
                end
                shadow_valid[slot] = 1'b1;
                shadow_key[slot]   = key;
                shadow_value[slot] = wdata;
                shadow_count[slot] = COUNT_ONE;
                shadow_stamp[slot] = shadow_tick;
                shadow_fill        = shadow_fill + 1;
            end
        end

        shadow_tick = shadow_tick + 1;
        res.hit     = present;
        return res;
    endfunction

    // Send one item, idling between bursts when bursty, and record its expected result
    task automatic send_request(input logic cmd, input logic [31:0] key, input logic [31:0] wdata);
        int gap;
        if (sender_bursty) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 12);
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        req_bus.valid       <= 1'b1;
        req_bus.cmd         <= cmd;
        req_bus.lookup_key  <= key;
        req_bus.write_value <= wdata;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        expected_lookups.push_back(predict_lookup(cmd, key, wdata));
    endtask

    // Hold off the sender until every expected result has come back
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the capacity register while the block is idle
    task automatic write_capacity(input logic [4:0] capacity);
        wait_drained();
        cfg_bus.valid           <= 1'b1;
        cfg_bus.capacity_in_use <= capacity;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        shadow_capacity = capacity;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic refresh_key_pool(input int pool_size);
        key_pool.delete();
        repeat (pool_size) key_pool.push_back($urandom);
    endtask

    // Random gets and puts drawn mostly from the key pool
    task automatic run_random_traffic(input int n_items, input int put_percent);
        int          k;
        logic        cmd;
        logic [31:0] key;
        for (k = 0; k < n_items; k++) begin
            if (k % 150 == 149) wait_drained();
            key = ($urandom_range(0, 9) == 0) ? $urandom
                                              : key_pool[$urandom_range(0, key_pool.size() - 1)];
            cmd = ($urandom_range(0, 99) < put_percent) ? CMD_PUT : CMD_GET;
            send_request(cmd, key, $urandom);
        end
    endtask

    // Extreme keys and values, get miss, put hit overwrite
    task automatic test_get_put_basics();
        send_request(CMD_GET, 32'h0000_0000, 32'h1234_5678);
        send_request(CMD_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
        send_request(CMD_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
        send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    endtask

    // Evict the least used entry, then the least recently touched among equals
    task automatic test_lfu_replacement();
        write_capacity(5'd2);
        send_request(CMD_PUT, 32'hA5A5_0001, 32'h0000_0011);
        send_request(CMD_PUT, 32'h5A5A_0002, 32'h0000_0022);
        send_request(CMD_GET, 32'hA5A5_0001, 32'h0000_0000);
        send_request(CMD_PUT, 32'hC3C3_0003, 32'h0000_0033);
        send_request(CMD_GET, 32'h5A5A_0002, 32'h0000_0000);
        send_request(CMD_GET, 32'hC3C3_0003, 32'h0000_0000);
        send_request(CMD_PUT, 32'h3C3C_0004, 32'h0000_0044);
        send_request(CMD_GET, 32'hA5A5_0001, 32'h0000_0000);
    endtask

    // Zero capacity: puts change nothing but still report presence
    task automatic test_zero_capacity();
        write_capacity(5'd0);
        send_request(CMD_PUT, 32'h3C3C_0004, 32'hDEAD_BEEF);
        send_request(CMD_GET, 32'h3C3C_0004, 32'h0000_0000);
        send_request(CMD_PUT, 32'h0F0F_0005, 32'h0000_0055);
        send_request(CMD_GET, 32'h0F0F_0005, 32'h0000_0000);
    endtask

    // Capacity above the table size is clamped to the table size
    task automatic test_oversized_capacity();
        write_capacity(5'd31);
        refresh_key_pool(24);
        run_random_traffic(350, 60);
    endtask

    // Capacity lowered below the fill keeps entries and evicts on each put miss
    task automatic test_shrunk_capacity();
        write_capacity(5'd3);
        refresh_key_pool(8);
        run_random_traffic(250, 50);
        write_capacity(5'd1);
        refresh_key_pool(4);
        run_random_traffic(200, 50);
    endtask

    // Full capacity with mostly hits, first with no idling on either side
    task automatic test_steady_traffic();
        write_capacity(5'd16);
        refresh_key_pool(12);
        sender_bursty   = 1'b0;
        receiver_stalls = 1'b0;
        run_random_traffic(150, 40);
        sender_bursty   = 1'b1;
        receiver_stalls = 1'b1;
        run_random_traffic(150, 40);
    endtask

    // Several capacities in turn, including zero over a populated table
    task automatic test_mixed_capacity();
        write_capacity(5'd7);
        refresh_key_pool(20);
        run_random_traffic(300, 55);
        write_capacity(5'd0);
        run_random_traffic(100, 60);
        write_capacity(5'd16);
        refresh_key_pool(40);
        run_random_traffic(200, 55);
    endtask

    // Receiver ready: short random stalls with occasional long ones, when stalls are enabled
    always @(posedge i_clk) begin
        if (!receiver_stalls) begin
            stall_left = 0;
            rsp_bus.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 24) == 0) begin
            stall_left = $urandom_range(4, 40);
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_lookup_result exp_res;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_lookups.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("ERROR: unexpected result hit=%0b read_value=%h",
                             rsp_bus.hit, rsp_bus.read_value);
                end
            end else begin
                exp_res = expected_lookups.pop_front();
                if (rsp_bus.hit !== exp_res.hit || rsp_bus.read_value !== exp_res.read_value) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("ERROR: hit exp %0b got %0b, read_value exp %h got %h",
                                 exp_res.hit, rsp_bus.hit, exp_res.read_value,
                                 rsp_bus.read_value);
                    end
                end
            end
        end
    end

    // Hard stop if the block hangs
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        error_count     = 0;
        burst_left      = 0;
        sender_bursty   = 1'b1;
        receiver_stalls = 1'b1;
        shadow_tick     = '0;
        shadow_fill     = 0;
        shadow_capacity = CAP_RESET;
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;

        i_rst_n                 <= 1'b0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.capacity_in_use <= CAP_RESET;
        req_bus.valid           <= 1'b0;
        req_bus.cmd             <= CMD_GET;
        req_bus.lookup_key      <= '0;
        req_bus.write_value     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_get_put_basics();
        test_lfu_replacement();
        test_zero_capacity();
        test_oversized_capacity();
        test_shrunk_capacity();
        test_steady_traffic();
        test_mixed_capacity();

        wait_drained();
        error_count += expected_lookups.size();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
